### rtl/core/lmsdb_pkg.sv
// ----------------------------------------------------------------------------
// LED matrix scan package
// Command codes, word layouts and colour helpers shared by the scan driver.
// ----------------------------------------------------------------------------
package lmsdb_pkg;

  localparam int unsigned RowW   = 3;
  localparam int unsigned ColorW = 24;

  typedef enum logic [2:0] {
    CMD_SET_PIXEL = 3'd0,
    CMD_FILL      = 3'd1,
    CMD_REPAINT   = 3'd2,
    CMD_WHITE_BAL = 3'd3,
    CMD_TICK      = 3'd4
  } cmd_e;

  // white balance shifts only the low 6 bits of each colour
  localparam logic [ColorW-1:0] WbMask = 24'h3F3F3F;

  typedef struct packed {
    logic [2:0]        command;
    logic [2:0]        column;
    logic [RowW-1:0]   row;
    logic [ColorW-1:0] color;
  } cmd_word_t;

  typedef struct packed {
    logic [ColorW-1:0] shift_word;
    logic              six_bit_mode;
    logic              bank_select;
    logic              latch_pulse;
    logic [7:0]        row_enable;
    logic              last;
  } out_word_t;

  // side information that travels with a word through the read pipeline
  typedef struct packed {
    logic              from_mem;
    logic [ColorW-1:0] cword;
    logic              six;
    logic              bank;
    logic              latch;
    logic [7:0]        rows;
    logic              last;
  } word_tag_t;

  // red/green/blue in, blue/green/red out
  function automatic logic [ColorW-1:0] to_shift_order(input logic [ColorW-1:0] c);
    return {c[7:0], c[15:8], c[23:16]};
  endfunction

  function automatic logic [7:0] row_onehot(input logic [RowW-1:0] r);
    return 8'h01 << r;
  endfunction

endpackage

### rtl/core/lmsdb_stream_if.sv
// ----------------------------------------------------------------------------
// Valid/ready stream channel
// One word per clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface lmsdb_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

### rtl/core/led_matrix_scan_double_buffer.sv
// ----------------------------------------------------------------------------
// LED matrix row-scan driver, double buffered
// Top level: frame memory, command sequencer and output stage.
// ----------------------------------------------------------------------------
// Drives an 8-row RGB LED matrix from two frame banks held in one memory of
// 16 * 2**CW words, CW = max(1, ceil(log2(COLUMNS))) (128 at the default).
// After reset a clearing pass zeroes the memory, one word a cycle, and no
// command is taken until it ends. A set_pixel is written in the cycle it is
// taken. tick and set_white_balance produce COLUMNS words at one word per
// cycle while the output stage is ready; the next command is taken as soon as
// the last word has been issued. fill writes all 8 * 2**CW words of the write
// bank; repaint copies them to the other bank and swaps banks; both go one
// memory word a cycle, repaint only while the output stage is ready. Output
// words wait in a register and a read stage; a stalled sink never loses one.
// ----------------------------------------------------------------------------
module led_matrix_scan_double_buffer
  import lmsdb_pkg::*;
#(
  parameter int COLUMNS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  lmsdb_stream_if.sink   cmd_i,
  lmsdb_stream_if.source word_o
);

  localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int AW = RowW + CW + 1;

  logic              issue_valid;
  word_tag_t         issue_tag;
  logic              issue_ready;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [ColorW-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [ColorW-1:0] mem_rdata;

  lmsdb_frame_ram #(
    .AW (AW),
    .DW (ColorW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  lmsdb_ctrl #(
    .COLUMNS (COLUMNS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_i),
    .issue_valid_o (issue_valid),
    .issue_tag_o   (issue_tag),
    .issue_ready_i (issue_ready),
    .rdata_i       (mem_rdata),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr)
  );

  lmsdb_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .issue_valid_i (issue_valid),
    .issue_tag_i   (issue_tag),
    .issue_ready_o (issue_ready),
    .rdata_i       (mem_rdata),
    .word_o        (word_o)
  );

  // a read and a write never hit the same word in one cycle
  a_no_rw_same_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("frame memory read and write collide");

  // a latched word opens exactly one row and closes a pixel run
  a_latch_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_o.valid && word_o.payload.latch_pulse |->
      $onehot(word_o.payload.row_enable) && word_o.payload.last &&
      word_o.payload.bank_select && !word_o.payload.six_bit_mode)
    else $error("latch word malformed");

  // no command is taken while the last repaint copy write is still pending
  a_no_accept_mid_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.valid && cmd_i.ready |=> !(mem_we && $past(mem_re) && !issue_valid &&
      $past(cmd_i.payload.command) == CMD_SET_PIXEL && mem_waddr == $past(mem_raddr)))
    else $error("command taken during repaint copy");

endmodule

### rtl/core/lmsdb_frame_ram.sv
// ----------------------------------------------------------------------------
// Frame memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module lmsdb_frame_ram #(
  parameter int AW = 7,
  parameter int DW = 24
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while the read port is idle
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/lmsdb_out_stage.sv
// ----------------------------------------------------------------------------
// Output stage
// Read-data stage plus output register; stalls hold both without loss.
// ----------------------------------------------------------------------------
module lmsdb_out_stage
  import lmsdb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              issue_valid_i,
  input  word_tag_t         issue_tag_i,
  output logic              issue_ready_o,
  input  logic [ColorW-1:0] rdata_i,
  lmsdb_stream_if.source    word_o
);

  logic      s1_valid_q, s1_valid_d;
  word_tag_t s1_tag_q;
  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q, out_word_d;
  logic      adv_out;
  logic      issue_fire;

  assign adv_out       = !out_valid_q || word_o.ready;
  assign issue_ready_o = !s1_valid_q || adv_out;
  assign issue_fire    = issue_valid_i && issue_ready_o;

  always_comb begin
    s1_valid_d  = issue_fire ? 1'b1 : (adv_out ? 1'b0 : s1_valid_q);
    out_valid_d = adv_out ? s1_valid_q : out_valid_q;
    // memory data arrives registered with stage one and holds until the next read
    out_word_d.shift_word   = s1_tag_q.from_mem ? to_shift_order(rdata_i) : s1_tag_q.cword;
    out_word_d.six_bit_mode = s1_tag_q.six;
    out_word_d.bank_select  = s1_tag_q.bank;
    out_word_d.latch_pulse  = s1_tag_q.latch;
    out_word_d.row_enable   = s1_tag_q.rows;
    out_word_d.last         = s1_tag_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_fire) begin
      s1_tag_q <= issue_tag_i;
    end
    if (adv_out && s1_valid_q) begin
      out_word_q <= out_word_d;
    end
  end

  assign word_o.valid   = out_valid_q;
  assign word_o.payload = out_word_q;

endmodule

### rtl/core/lmsdb_ctrl.sv
// ----------------------------------------------------------------------------
// Command sequencer
// Decodes commands, walks the frame memory and issues shift words.
// ----------------------------------------------------------------------------
module lmsdb_ctrl
  import lmsdb_pkg::*;
#(
  parameter int COLUMNS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  lmsdb_stream_if.sink      cmd_i,
  output logic              issue_valid_o,
  output word_tag_t         issue_tag_o,
  input  logic              issue_ready_i,
  input  logic [ColorW-1:0] rdata_i,
  output logic              mem_we_o,
  output logic [RowW+((COLUMNS > 1) ? $clog2(COLUMNS) : 1):0] mem_waddr_o,
  output logic [ColorW-1:0] mem_wdata_o,
  output logic              mem_re_o,
  output logic [RowW+((COLUMNS > 1) ? $clog2(COLUMNS) : 1):0] mem_raddr_o
);

  localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int BW = RowW + CW;  // one bank
  localparam int AW = BW + 1;     // both banks

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_COPY,
    ST_EMIT
  } state_e;

  state_e            state_q, state_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  logic [2:0]        cmd_q, cmd_d;
  logic [ColorW-1:0] color_q, color_d;
  logic              write_bank_q, write_bank_d;
  logic [RowW-1:0]   scan_row_q, scan_row_d;
  logic [7:0]        open_rows_q, open_rows_d;
  logic              cp_valid_q, cp_valid_d;
  logic [AW-1:0]     cp_addr_q, cp_addr_d;

  logic accept;
  logic pixel_ok;
  logic last_col;
  logic bank_end;
  logic is_tick;
  logic issue_fire;

  assign cmd_i.ready = (state_q == ST_IDLE) && !cp_valid_q;
  assign accept      = cmd_i.valid && cmd_i.ready;
  // row is always in range with eight rows
  assign pixel_ok    = int'(cmd_i.payload.column) < COLUMNS;
  assign last_col    = cnt_q[CW-1:0] == CW'(COLUMNS - 1);
  assign bank_end    = &cnt_q[BW-1:0];
  assign is_tick     = cmd_q == CMD_TICK;

  assign issue_valid_o = state_q == ST_EMIT;
  assign issue_fire    = issue_valid_o && issue_ready_i;

  always_comb begin
    issue_tag_o.from_mem = is_tick;
    issue_tag_o.cword    = to_shift_order(color_q & WbMask);
    issue_tag_o.six      = !is_tick;
    issue_tag_o.bank     = is_tick;
    issue_tag_o.latch    = is_tick && last_col;
    issue_tag_o.rows     = is_tick ? (last_col ? row_onehot(scan_row_q) : 8'h00)
                                   : open_rows_q;
    issue_tag_o.last     = last_col;
  end

  // read port: tick pixels, or the source bank during a repaint
  assign mem_re_o = (issue_fire && is_tick) || ((state_q == ST_COPY) && issue_ready_i);
  assign mem_raddr_o = (state_q == ST_COPY) ? {write_bank_q, cnt_q[BW-1:0]}
                                            : {~write_bank_q, scan_row_q, cnt_q[CW-1:0]};

  // write port
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = cnt_q;
    mem_wdata_o = '0;
    if (cp_valid_q) begin
      mem_we_o    = 1'b1;
      mem_waddr_o = cp_addr_q;
      mem_wdata_o = rdata_i;
    end else if (state_q == ST_CLEAR) begin
      mem_we_o = 1'b1;
    end else if (state_q == ST_FILL) begin
      mem_we_o    = 1'b1;
      mem_waddr_o = {write_bank_q, cnt_q[BW-1:0]};
      mem_wdata_o = color_q;
    end else if (accept && (cmd_i.payload.command == CMD_SET_PIXEL) && pixel_ok) begin
      mem_we_o    = 1'b1;
      mem_waddr_o = {write_bank_q, cmd_i.payload.row, CW'(cmd_i.payload.column)};
      mem_wdata_o = cmd_i.payload.color;
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cmd_d        = cmd_q;
    color_d      = color_q;
    write_bank_d = write_bank_q;
    scan_row_d   = scan_row_q;
    open_rows_d  = open_rows_q;
    cp_valid_d   = 1'b0;
    cp_addr_d    = cp_addr_q;
    unique case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + AW'(1);
        if (&cnt_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_d   = cmd_i.payload.command;
          color_d = cmd_i.payload.color;
          cnt_d   = '0;
          case (cmd_i.payload.command)
            CMD_FILL:                state_d = ST_FILL;
            CMD_REPAINT:             state_d = ST_COPY;
            CMD_WHITE_BAL, CMD_TICK: state_d = ST_EMIT;
            default:                 state_d = ST_IDLE;
          endcase
        end
      end
      ST_FILL: begin
        cnt_d = cnt_q + AW'(1);
        if (bank_end) begin
          state_d = ST_IDLE;
        end
      end
      ST_COPY: begin
        // write-bank entry k lands in the display bank in the cycle after its read
        if (issue_ready_i) begin
          cp_valid_d = 1'b1;
          cp_addr_d  = {~write_bank_q, cnt_q[BW-1:0]};
          cnt_d      = cnt_q + AW'(1);
          if (bank_end) begin
            write_bank_d = ~write_bank_q;
            state_d      = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        if (issue_fire) begin
          cnt_d = cnt_q + AW'(1);
          if (last_col) begin
            state_d = ST_IDLE;
            if (is_tick) begin
              open_rows_d = row_onehot(scan_row_q);
              scan_row_d  = scan_row_q + RowW'(1);
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      cnt_q        <= '0;
      cmd_q        <= '0;
      color_q      <= '0;
      write_bank_q <= 1'b0;
      scan_row_q   <= '0;
      open_rows_q  <= '0;
      cp_valid_q   <= 1'b0;
      cp_addr_q    <= '0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      cmd_q        <= cmd_d;
      color_q      <= color_d;
      write_bank_q <= write_bank_d;
      scan_row_q   <= scan_row_d;
      open_rows_q  <= open_rows_d;
      cp_valid_q   <= cp_valid_d;
      cp_addr_q    <= cp_addr_d;
    end
  end

endmodule
